// ----- rtl/two_axis_stepper_packet_controller_top_defines.svh -----
// ----------------------------------------------------------------------------
// Two-axis stepper packet controller assertion macros
// Immediate-implication and next-cycle checks clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_STEPPER_PACKET_CONTROLLER_TOP_DEFINES_SVH
`define TWO_AXIS_STEPPER_PACKET_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TASP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tasp check failed");
`define TASP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tasp check failed");
`else
`define TASP_ASSERT_IMP(lbl, ante, cons)
`define TASP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/tasp_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-axis stepper packet controller package
// Packet framing constants, command codes and shared structs.
// ----------------------------------------------------------------------------
package tasp_pkg;

  localparam int POSITION_WIDTH_DEF = 16;

  localparam logic [7:0]  START_MARK   = 8'd255;
  localparam logic [7:0]  FORCED_BYTE  = 8'd255;
  localparam logic [15:0] RESET_PERIOD = 16'd4713;
  localparam int          PACKET_LEN   = 12;
  localparam int          STORE_LEN    = 10;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CMD_ZERO_ALL   = 8'd0;
  localparam logic [7:0] CMD_LOAD_GOAL  = 8'd1;
  localparam logic [7:0] CMD_CLEAR_GOAL = 8'd2;

  typedef struct packed {
    logic        apply;
    logic [7:0]  cmd;
    logic [15:0] x_goal;
    logic [15:0] y_goal;
    logic [15:0] x_period;
    logic [15:0] y_period;
  } pkt_apply_t;

  typedef struct packed {
    logic        tick;
    logic        motion_en;
    logic        load;
    logic        zero_pos;
    logic        set_goal;
    logic        clr_goal;
    logic [15:0] goal;
    logic [15:0] period;
  } axis_cmd_t;

  typedef struct packed {
    logic        step;
    logic        dir;
    logic [15:0] pos;
  } axis_view_t;

endpackage

// ----- rtl/two_axis_stepper_packet_controller_top.sv -----
// ----------------------------------------------------------------------------
// Two-axis stepper packet controller
// Each word passes the input register, then the state update into the result register.
// Throughput one word per cycle while out_ready is not held low, set by the single-pass update of both axes.
// Sync reset: framer waits for start, axes home at period 4713, motion off.
// ----------------------------------------------------------------------------
`include "two_axis_stepper_packet_controller_top_defines.svh"

module two_axis_stepper_packet_controller_top import tasp_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        x_step,
  output logic        x_dir,
  output logic        y_step,
  output logic        y_dir,
  output logic [15:0] x_position,
  output logic [15:0] y_position,
  output logic        packet_done
);

  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;
  logic       advance;
  logic       motion_en;
  pkt_apply_t pkt;
  axis_cmd_t  x_cmd;
  axis_cmd_t  y_cmd;
  axis_view_t x_view;
  axis_view_t y_view;
  logic       x_step_level;
  logic       y_step_level;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= operation;
      s1_byte <= rx_byte;
    end
  end

  tasp_packet_rx u_packet_rx (
    .clk     (clk),
    .rst     (rst),
    .wr      (advance && s1_op == OP_BYTE),
    .rx_data (s1_byte),
    .pkt     (pkt)
  );

  always_comb begin
    x_cmd.tick      = advance && s1_op == OP_TICK;
    x_cmd.motion_en = motion_en;
    x_cmd.load      = pkt.apply;
    x_cmd.zero_pos  = (pkt.cmd == CMD_ZERO_ALL);
    x_cmd.set_goal  = (pkt.cmd == CMD_LOAD_GOAL);
    x_cmd.clr_goal  = (pkt.cmd == CMD_CLEAR_GOAL);
    x_cmd.goal      = pkt.x_goal;
    x_cmd.period    = pkt.x_period;
    y_cmd           = x_cmd;
    y_cmd.goal      = pkt.y_goal;
    y_cmd.period    = pkt.y_period;
  end

  tasp_axis #(.POSITION_WIDTH(POSITION_WIDTH)) u_axis_x (
    .clk        (clk),
    .rst        (rst),
    .cmd        (x_cmd),
    .view_next  (x_view),
    .step_level (x_step_level)
  );

  tasp_axis #(.POSITION_WIDTH(POSITION_WIDTH)) u_axis_y (
    .clk        (clk),
    .rst        (rst),
    .cmd        (y_cmd),
    .view_next  (y_view),
    .step_level (y_step_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_en <= 1'b0;
    end else if (pkt.apply) begin
      motion_en <= 1'b1;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_step      <= x_view.step;
      x_dir       <= x_view.dir;
      y_step      <= y_view.step;
      y_dir       <= y_view.dir;
      x_position  <= x_view.pos;
      y_position  <= y_view.pos;
      packet_done <= pkt.apply;
    end
  end

  `TASP_ASSERT_NXT(a_advance_fills, advance, out_valid)
  `TASP_ASSERT_IMP(a_no_overwrite, out_valid && !out_ready, !advance)
  `TASP_ASSERT_NXT(a_tick_no_done, advance && s1_op == OP_TICK, !packet_done)
  `TASP_ASSERT_IMP(a_idle_no_step, !motion_en, !x_step_level && !y_step_level)

endmodule

// ----- rtl/tasp_packet_rx.sv -----
// ----------------------------------------------------------------------------
// Packet receiver
// Frames the 12-byte packet, holds its body and decodes the words on the
// escape byte.
// ----------------------------------------------------------------------------
module tasp_packet_rx import tasp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  logic [7:0] rx_data,
  output pkt_apply_t pkt
);

  localparam logic [3:0] LAST_INDEX = 4'(PACKET_LEN - 1);

  logic [3:0] byte_index;
  logic [3:0] byte_index_next;
  logic [7:0] store [STORE_LEN];
  logic [7:0] data_byte [8];
  logic       is_last;

  assign is_last = (byte_index >= LAST_INDEX);

  always_comb begin
    byte_index_next = byte_index;
    if (wr) begin
      if (byte_index == 4'd0) begin
        if (rx_data == START_MARK) byte_index_next = 4'd1;
      end else if (is_last) begin
        byte_index_next = 4'd0;
      end else begin
        byte_index_next = byte_index + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 4'd0;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STORE_LEN; k++) begin
      if (wr && !is_last && byte_index == 4'(k + 1)) store[k] <= rx_data;
    end
  end

  // escape bit 7-k forces data byte k
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      data_byte[k] = rx_data[7 - k] ? FORCED_BYTE : store[2 + k];
    end
  end

  always_comb begin
    pkt.apply    = wr && is_last;
    pkt.cmd      = store[0];
    pkt.x_goal   = {data_byte[0], data_byte[1]};
    pkt.y_goal   = {data_byte[2], data_byte[3]};
    pkt.x_period = {data_byte[4], data_byte[5]};
    pkt.y_period = {data_byte[6], data_byte[7]};
  end

endmodule

// ----- rtl/tasp_axis.sv -----
// ----------------------------------------------------------------------------
// Axis step generator
// Position, target, period counter and step/dir line levels for one axis.
// ----------------------------------------------------------------------------
module tasp_axis import tasp_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  axis_cmd_t  cmd,
  output axis_view_t view_next,
  output logic       step_level
);

  logic [POSITION_WIDTH-1:0] pos;
  logic [POSITION_WIDTH-1:0] pos_next;
  logic [POSITION_WIDTH-1:0] goal;
  logic [POSITION_WIDTH-1:0] goal_next;
  logic [15:0]               period;
  logic [15:0]               period_next;
  logic [15:0]               count;
  logic [15:0]               count_next;
  logic                      step;
  logic                      step_next;
  logic                      dir;
  logic                      dir_next;

  always_comb begin
    pos_next    = pos;
    goal_next   = goal;
    period_next = period;
    count_next  = count;
    step_next   = step;
    dir_next    = dir;
    if (cmd.tick && period != 16'd0) begin
      if (cmd.motion_en) begin
        // drop first, so a step on the same tick wins
        if (count == (period >> 1)) step_next = 1'b0;
        if (count == 16'd0) begin
          if (pos < goal) begin
            dir_next  = 1'b1;
            step_next = 1'b1;
            pos_next  = pos + POSITION_WIDTH'(1);
          end else if (pos > goal) begin
            dir_next  = 1'b0;
            step_next = 1'b1;
            pos_next  = pos - POSITION_WIDTH'(1);
          end
        end
      end
      if (count >= period) count_next = 16'd0;
      else                 count_next = count + 16'd1;
    end
    if (cmd.load) begin
      if (cmd.zero_pos) begin
        pos_next  = '0;
        goal_next = '0;
      end else if (cmd.set_goal) begin
        goal_next = POSITION_WIDTH'(cmd.goal);
      end else if (cmd.clr_goal) begin
        goal_next = '0;
      end
      period_next = cmd.period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      goal   <= '0;
      period <= RESET_PERIOD;
      count  <= 16'd0;
      step   <= 1'b0;
      dir    <= 1'b1;
    end else begin
      pos    <= pos_next;
      goal   <= goal_next;
      period <= period_next;
      count  <= count_next;
      step   <= step_next;
      dir    <= dir_next;
    end
  end

  assign view_next.step = step_next;
  assign view_next.dir  = dir_next;
  assign view_next.pos  = 16'(pos_next);
  assign step_level     = step;

endmodule
